@@ rtl/core/ptc_pkg.sv @@
// Shared types, register indexes and fixed-point helpers for the pressure and
// temperature compensation pipeline. No dependencies.
package ptc_pkg;

	// Width of the shared restoring divider (one quotient bit per stage).
	localparam int DIV_W = 64;
	localparam int REG_IDX_W = 3;

	// Configuration register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_TEMP_CAL   = 3'd0,
		REG_PRESS_LOW  = 3'd1,
		REG_PRESS_HIGH = 3'd2,
		REG_PRESS_P9   = 3'd3,
		REG_MODE       = 3'd4
	} reg_idx_t;

	// Calibration words as the pipeline sees them.
	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
		logic        mode;
	} cal_t;

	// Data that rides alongside the divider.
	typedef struct packed {
		logic [31:0] tc;
		logic [31:0] tf;
		logic        dz;
		logic        neg;
		logic        shl;
	} side_t;

	typedef struct packed {
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
		side_t            side;
	} div_req_t;

	function automatic logic [31:0] sx32(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sx64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
		return 32'($signed(v) >>> s);
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned s);
		return 64'($signed(v) >>> s);
	endfunction

endpackage

@@ rtl/core/pressure_temperature_compensation.sv @@
// Top level of the barometric compensation pipeline: configuration registers,
// input skid register and the temperature, pre-divide, divider and post stages.
// Depends on ptc_pkg, ptc_temp, ptc_pre, ptc_div and ptc_post.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------------
//   input    | in_valid / in_ready     | raw_temperature, raw_pressure
//   output   | out_valid / out_ready   | temperature_centi, fine_temperature,
//            |                         | pressure, divide_by_zero
//   config   | wr_en (no wait)         | wr_index, wr_data
//
// One request per cycle while no result is stalled; each passes through the 64 stages of
// the restoring divider plus 12 arithmetic stages.
// Reset clears the calibration registers and all valid bits.
// A stalled result holds the whole pipeline; one further input request is
// caught in the skid register, and in_ready drops only while it is full.
module pressure_temperature_compensation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [19:0]         raw_temperature,
	input  logic [19:0]         raw_pressure,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  temperature_centi,
	output logic signed [31:0]  fine_temperature,
	output logic [31:0]         pressure,
	output logic                divide_by_zero,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [63:0]         wr_data
);
	import ptc_pkg::*;

	logic [47:0] temp_cal_q;
	logic [63:0] press_low_q, press_high_q;
	logic [15:0] p9_q;
	logic        mode_q;
	cal_t        cal;

	logic        en;
	logic        skid_vld_q;
	logic [19:0] skid_t_q, skid_p_q;
	logic        feed_vld;
	logic [19:0] feed_t, feed_p;

	logic        vld_s2, vld_s7, quo_vld;
	logic [31:0] tf_s2;
	logic [19:0] adc_p_s2;
	div_req_t    req_s7;
	logic [DIV_W-1:0] quo;
	side_t       quo_side;
	logic [31:0] tc_o, tf_o, press_o;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q   <= '0;
			press_low_q  <= '0;
			press_high_q <= '0;
			p9_q         <= '0;
			mode_q       <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_TEMP_CAL:   temp_cal_q   <= wr_data[47:0];
				REG_PRESS_LOW:  press_low_q  <= wr_data;
				REG_PRESS_HIGH: press_high_q <= wr_data;
				REG_PRESS_P9:   p9_q         <= wr_data[15:0];
				REG_MODE:       mode_q       <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cal.t1   = temp_cal_q[15:0];
		cal.t2   = temp_cal_q[31:16];
		cal.t3   = temp_cal_q[47:32];
		cal.p1   = press_low_q[15:0];
		cal.p2   = press_low_q[31:16];
		cal.p3   = press_low_q[47:32];
		cal.p4   = press_low_q[63:48];
		cal.p5   = press_high_q[15:0];
		cal.p6   = press_high_q[31:16];
		cal.p7   = press_high_q[47:32];
		cal.p8   = press_high_q[63:48];
		cal.p9   = p9_q;
		cal.mode = mode_q;
	end

	// Whole pipeline advances unless the output register holds an untaken result.
	assign en       = ~out_valid | out_ready;
	assign in_ready = ~skid_vld_q;
	assign feed_vld = skid_vld_q | in_valid;
	assign feed_t   = skid_vld_q ? skid_t_q : raw_temperature;
	assign feed_p   = skid_vld_q ? skid_p_q : raw_pressure;

	// Skid register catches a request taken during a stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_valid && in_ready) begin
			skid_t_q <= raw_temperature;
			skid_p_q <= raw_pressure;
		end
	end

	ptc_temp u_temp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (feed_vld),
		.raw_t    (feed_t),
		.raw_p    (feed_p),
		.cal      (cal),
		.vld_s2   (vld_s2),
		.tf_s2    (tf_s2),
		.adc_p_s2 (adc_p_s2)
	);

	ptc_pre u_pre (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (vld_s2),
		.tf     (tf_s2),
		.adc_p  (adc_p_s2),
		.cal    (cal),
		.vld_s7 (vld_s7),
		.req_s7 (req_s7)
	);

	ptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.req_vld  (vld_s7),
		.req      (req_s7),
		.quo_vld  (quo_vld),
		.quo      (quo),
		.quo_side (quo_side)
	);

	ptc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.quo_vld   (quo_vld),
		.quo       (quo),
		.quo_side  (quo_side),
		.cal       (cal),
		.vld_s76   (out_valid),
		.tc_s76    (tc_o),
		.tf_s76    (tf_o),
		.press_s76 (press_o),
		.dz_s76    (divide_by_zero)
	);

	assign temperature_centi = tc_o;
	assign fine_temperature  = tf_o;
	assign pressure          = press_o;

endmodule

@@ rtl/core/ptc_temp.sv @@
// Temperature stages: fine temperature from the raw temperature and T1..T3.
// Depends on ptc_pkg.
module ptc_temp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [19:0]   raw_t,
	input  logic [19:0]   raw_p,
	input  ptc_pkg::cal_t cal,
	output logic          vld_s2,
	output logic [31:0]   tf_s2,
	output logic [19:0]   adc_p_s2
);
	import ptc_pkg::*;

	logic        vld_s1;
	logic [31:0] prod_s1, dd_s1;
	logic [19:0] adc_p_s1;
	logic [31:0] x, d;

	// Linear and square terms of the raw temperature.
	assign x = {15'b0, raw_t[19:3]} - {15'b0, cal.t1, 1'b0};
	assign d = {16'b0, raw_t[19:4]} - {16'b0, cal.t1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= x * sx32(cal.t2);
			dd_s1    <= d * d;
			adc_p_s1 <= raw_p;
			tf_s2    <= asr32(prod_s1, 11) + asr32(asr32(dd_s1, 12) * sx32(cal.t3), 14);
			adc_p_s2 <= adc_p_s1;
		end
	end

endmodule

@@ rtl/core/ptc_pre.sv @@
// Pressure stages before the division: both paths build their dividend and
// divisor, then the selected pair is turned into a magnitude request. Uses ptc_pkg.
module ptc_pre (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [31:0]       tf,
	input  logic [19:0]       adc_p,
	input  ptc_pkg::cal_t     cal,
	output logic              vld_s7,
	output ptc_pkg::div_req_t req_s7
);
	import ptc_pkg::*;

	logic vld_s3, vld_s4, vld_s5, vld_s6;
	logic [31:0] tf_s3, tf_s4, tf_s5, tf_s6;
	logic [31:0] tc_s3, tc_s4, tc_s5, tc_s6;
	logic [19:0] adc_s3, adc_s4, adc_s5;

	// Stage 3 products.
	logic [31:0] qq0_s3, a0p5_s3, a0p2_s3;
	logic [63:0] aa1_s3, a1p5_s3, a1p2_s3;
	// Stage 4 products.
	logic [31:0] b0_s4, t0_s4, a0p5_s4, a0p2_s4;
	logic [63:0] b1_s4, t1_s4, a1p5_s4, a1p2_s4;
	// Stage 5 sums.
	logic [31:0] b0_s5, af0_s5;
	logic [63:0] b1_s5, af1_s5;
	// Stage 6 dividends and divisors.
	logic [31:0] pn0_s6, dv0_s6;
	logic [63:0] pn1_s6, dv1_s6;

	logic [31:0] m0a, q0;
	logic [63:0] m1a, base1;
	logic signed [32:0] a33;
	logic signed [65:0] aa_full;
	logic        big0;
	div_req_t    req;

	assign m0a     = asr32(tf, 1) - 32'd64000;
	assign q0      = asr32(m0a, 2);
	assign m1a     = {{32{tf[31]}}, tf} - 64'd128000;
	assign a33     = $signed(m1a[32:0]);
	// The offset temperature fits in 33 bits, so its square is a 33 by 33 product.
	assign aa_full = a33 * a33;
	assign base1   = 64'd1048576 - {44'b0, adc_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s3 <= in_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Stages 3 to 6: first-order and square terms, sums, then dividend and divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			tf_s3   <= tf;
			tc_s3   <= asr32(tf * 32'd5 + 32'd128, 8);
			adc_s3  <= adc_p;
			qq0_s3  <= q0 * q0;
			a0p5_s3 <= m0a * sx32(cal.p5);
			a0p2_s3 <= m0a * sx32(cal.p2);
			aa1_s3  <= aa_full[63:0];
			a1p5_s3 <= m1a * sx64(cal.p5);
			a1p2_s3 <= m1a * sx64(cal.p2);

			tf_s4   <= tf_s3;
			tc_s4   <= tc_s3;
			adc_s4  <= adc_s3;
			b0_s4   <= asr32(qq0_s3, 11) * sx32(cal.p6);
			t0_s4   <= sx32(cal.p3) * asr32(qq0_s3, 13);
			b1_s4   <= aa1_s3 * sx64(cal.p6);
			t1_s4   <= aa1_s3 * sx64(cal.p3);
			a0p5_s4 <= a0p5_s3;
			a0p2_s4 <= a0p2_s3;
			a1p5_s4 <= a1p5_s3;
			a1p2_s4 <= a1p2_s3;

			tf_s5   <= tf_s4;
			tc_s5   <= tc_s4;
			adc_s5  <= adc_s4;
			b0_s5   <= asr32(b0_s4 + {a0p5_s4[30:0], 1'b0}, 2) + {cal.p4, 16'b0};
			af0_s5  <= asr32(asr32(t0_s4, 3) + asr32(a0p2_s4, 1), 18);
			b1_s5   <= b1_s4 + {a1p5_s4[46:0], 17'b0}
				+ {{13{cal.p4[15]}}, cal.p4, 35'b0};
			af1_s5  <= asr64(t1_s4, 8) + {a1p2_s4[51:0], 12'b0};

			tf_s6   <= tf_s5;
			tc_s6   <= tc_s5;
			dv0_s6  <= asr32((32'd32768 + af0_s5) * {16'b0, cal.p1}, 15);
			pn0_s6  <= ((32'd1048576 - {12'b0, adc_s5}) - asr32(b0_s5, 12)) * 32'd3125;
			dv1_s6  <= asr64((64'h0000_8000_0000_0000 + af1_s5) * {48'b0, cal.p1}, 33);
			pn1_s6  <= ({base1[32:0], 31'b0} - b1_s5) * 64'd3125;
		end
	end

	// Divider request: the short path doubles before or after dividing,
	// the long path divides magnitudes and fixes the sign afterwards.
	assign big0 = pn0_s6[31];
	always_comb begin
		req.side.tc = tc_s6;
		req.side.tf = tf_s6;
		if (cal.mode) begin
			req.num      = pn1_s6[63] ? -pn1_s6 : pn1_s6;
			req.den      = dv1_s6[63] ? -dv1_s6 : dv1_s6;
			req.side.dz  = (dv1_s6 == 64'd0);
			req.side.neg = pn1_s6[63] ^ dv1_s6[63];
			req.side.shl = 1'b0;
		end else begin
			req.num      = {32'b0, big0 ? pn0_s6 : {pn0_s6[30:0], 1'b0}};
			req.den      = {32'b0, dv0_s6};
			req.side.dz  = (dv0_s6 == 32'd0);
			req.side.neg = 1'b0;
			req.side.shl = big0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s7 <= req;
		end
	end

endmodule

@@ rtl/core/ptc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage, with the
// item's side data carried along. Uses ptc_pkg.
module ptc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      req_vld,
	input  ptc_pkg::div_req_t         req,
	output logic                      quo_vld,
	output logic [ptc_pkg::DIV_W-1:0] quo,
	output ptc_pkg::side_t            quo_side
);
	import ptc_pkg::*;

	logic [DIV_W-1:0] rem_s  [DIV_W];
	logic [DIV_W-1:0] num_s  [DIV_W];
	logic [DIV_W-1:0] den_s  [DIV_W];
	side_t            side_s [DIV_W];
	logic             vld_s  [DIV_W];

	genvar k;
	for (k = 0; k < DIV_W; k++) begin : g_stage
		logic [DIV_W-1:0] rem_in, num_in, den_in;
		side_t            side_in;
		logic             vld_in;
		logic [DIV_W:0]   trial;
		logic             hit;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign num_in  = req.num;
			assign den_in  = req.den;
			assign side_in = req.side;
			assign vld_in  = req_vld;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign num_in  = num_s[k-1];
			assign den_in  = den_s[k-1];
			assign side_in = side_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		// Bring down the next dividend bit and try one subtraction.
		assign trial = {rem_in, num_in[DIV_W-1]};
		assign hit   = (trial >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= hit ? DIV_W'(trial - {1'b0, den_in}) : trial[DIV_W-1:0];
				num_s[k]  <= {num_in[DIV_W-2:0], hit};
				den_s[k]  <= den_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign quo_vld  = vld_s[DIV_W-1];
	assign quo      = num_s[DIV_W-1];
	assign quo_side = side_s[DIV_W-1];

endmodule

@@ rtl/core/ptc_post.sv @@
// Pressure stages after the division: quotient fix-up, the P7..P9 correction
// for both paths and the output register. Uses ptc_pkg.
module ptc_post (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      quo_vld,
	input  logic [ptc_pkg::DIV_W-1:0] quo,
	input  ptc_pkg::side_t            quo_side,
	input  ptc_pkg::cal_t             cal,
	output logic                      vld_s76,
	output logic [31:0]               tc_s76,
	output logic [31:0]               tf_s76,
	output logic [31:0]               press_s76,
	output logic                      dz_s76
);
	import ptc_pkg::*;

	logic  vld_s72, vld_s73, vld_s74, vld_s75;
	side_t side_s72, side_s73, side_s74, side_s75;
	logic [63:0] p_s72, p_s73, p_s74, p_s75;
	logic [63:0] y_s73, x1_s73, pb1_s73, pb1_s74, pb1_s75;
	logic [31:0] hh_s73, pb0_s73, pb0_s74, pa0_s74;
	logic [63:0] ll_s74, prod_s75;
	logic [31:0] cross_s74, r0_s75;
	logic [31:0] q32, h;
	logic [63:0] pfix, r1;

	assign q32 = quo[31:0];
	assign h   = {3'b0, p_s72[31:3]};
	always_comb begin
		if (cal.mode) begin
			pfix = quo_side.neg ? -quo : quo;
		end else begin
			pfix = {32'b0, quo_side.shl ? {q32[30:0], 1'b0} : q32};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s72 <= 1'b0;
			vld_s73 <= 1'b0;
			vld_s74 <= 1'b0;
			vld_s75 <= 1'b0;
			vld_s76 <= 1'b0;
		end else if (en) begin
			vld_s72 <= quo_vld;
			vld_s73 <= vld_s72;
			vld_s74 <= vld_s73;
			vld_s75 <= vld_s74;
			vld_s76 <= vld_s75;
		end
	end

	// The long path's 64-bit square term is split into 32-bit partial products.
	assign r1 = asr64(p_s75 + asr64(prod_s75, 25) + asr64(pb1_s75, 19), 8)
		+ {{44{cal.p7[15]}}, cal.p7, 4'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			side_s72  <= quo_side;
			p_s72     <= pfix;

			side_s73  <= side_s72;
			p_s73     <= p_s72;
			hh_s73    <= h * h;
			pb0_s73   <= {2'b0, p_s72[31:2]} * sx32(cal.p8);
			y_s73     <= asr64(p_s72, 13);
			x1_s73    <= sx64(cal.p9) * asr64(p_s72, 13);
			pb1_s73   <= sx64(cal.p8) * p_s72;

			side_s74  <= side_s73;
			p_s74     <= p_s73;
			pb0_s74   <= pb0_s73;
			pb1_s74   <= pb1_s73;
			pa0_s74   <= sx32(cal.p9) * {13'b0, hh_s73[31:13]};
			ll_s74    <= {32'b0, x1_s73[31:0]} * {32'b0, y_s73[31:0]};
			cross_s74 <= x1_s73[63:32] * y_s73[31:0] + x1_s73[31:0] * y_s73[63:32];

			side_s75  <= side_s74;
			p_s75     <= p_s74;
			pb1_s75   <= pb1_s74;
			prod_s75  <= ll_s74 + {cross_s74, 32'b0};
			r0_s75    <= p_s74[31:0]
				+ asr32(asr32(pa0_s74, 12) + asr32(pb0_s74, 13) + sx32(cal.p7), 4);

			tc_s76    <= side_s75.tc;
			tf_s76    <= side_s75.tf;
			dz_s76    <= side_s75.dz;
			press_s76 <= side_s75.dz ? 32'd0 : (cal.mode ? r1[31:0] : r0_s75);
		end
	end

endmodule

@@ rtl/core/ptc_checker.sv @@
// Port-level checks for the compensation pipeline, bound to the top level.
// Depends only on the top-level ports.
module ptc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] temperature_centi,
	input logic signed [31:0] fine_temperature,
	input logic [31:0]        pressure,
	input logic               divide_by_zero
);

	logic [31:0] tc_chk;

	// Centi-degree result is fixed by the fine temperature of the same request.
	assign tc_chk = 32'($signed(fine_temperature * 32'sd5 + 32'sd128) >>> 8);

	// A held result stays valid and keeps its pressure, fine temperature and zero-divisor flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressure)
			&& $stable(fine_temperature) && $stable(divide_by_zero))
		else $error("output changed while stalled");

	a_tc_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_centi == tc_chk)
		else $error("temperature fields out of step");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> pressure == 32'd0)
		else $error("zero divisor with nonzero pressure");

	// Input backpressure only follows a request caught during a stall,
	// and clears as soon as the output side moves.
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready && out_valid && !out_ready))
		else $error("input ready dropped without a stalled request");

	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && (!out_valid || out_ready) |=> in_ready)
		else $error("input ready stuck low");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);

@@ verif/tb_pressure_temperature_compensation.sv @@
// Self-checking testbench for the barometric pressure and temperature compensation block.
// It needs ptc_pkg and the pressure_temperature_compensation RTL, and nothing else.
module tb_pressure_temperature_compensation;
	timeunit 1ns;
	timeprecision 1ps;
	import ptc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [2:0] IDX_UNUSED_LO = 3'd5;
	localparam logic [2:0] IDX_UNUSED_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [19:0] raw_temperature = '0;
	logic [19:0] raw_pressure = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] temperature_centi;
	logic signed [31:0] fine_temperature;
	logic [31:0] pressure;
	logic divide_by_zero;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = '0;
	logic [63:0] wr_data = '0;

	typedef struct {
		logic [31:0] centi;
		logic [31:0] fine;
		logic [31:0] press;
		logic        dz;
	} comp_t;

	// Expected readings in request order, plus our copy of the calibration.
	comp_t reading_q[$];
	logic [47:0] cal_temp = '0;
	logic [63:0] cal_press_lo = '0;
	logic [63:0] cal_press_hi = '0;
	logic [15:0] cal_p9 = '0;
	logic        cal_mode = 1'b0;

	int errors = 0;
	int requests = 0;
	int readings = 0;
	int dz_count = 0;
	int idle_cycles = 0;
	bit no_idle = 0;

	pressure_temperature_compensation uut (.*);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] ext32(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [63:0] ext64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sar32(input logic [31:0] v, input int s);
		return $unsigned($signed(v) >>> s);
	endfunction

	function automatic logic [63:0] sar64(input logic [63:0] v, input int s);
		return $unsigned($signed(v) >>> s);
	endfunction

	// Signed 64-bit divide truncating toward zero; the most negative value over -1 wraps.
	function automatic logic [63:0] div_trunc64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] an, ad, q;
		an = n[63] ? -n : n;
		ad = d[63] ? -d : d;
		q = an / ad;
		return (n[63] != d[63]) ? -q : q;
	endfunction

	// 32-bit pressure path, whole pascals.
	function automatic logic [31:0] pressure_pa(input logic [31:0] tf, input logic [19:0] adc,
			output logic dz);
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, q, p, h;
		p1 = {16'd0, cal_press_lo[15:0]};
		p2 = ext32(cal_press_lo[31:16]);
		p3 = ext32(cal_press_lo[47:32]);
		p4 = ext32(cal_press_lo[63:48]);
		p5 = ext32(cal_press_hi[15:0]);
		p6 = ext32(cal_press_hi[31:16]);
		p7 = ext32(cal_press_hi[47:32]);
		p8 = ext32(cal_press_hi[63:48]);
		p9 = ext32(cal_p9);
		dz = 1'b0;
		a = sar32(tf, 1) - 32'd64000;
		q = sar32(a, 2);
		b = sar32(q * q, 11) * p6;
		b = b + ((a * p5) << 1);
		b = sar32(b, 2) + (p4 << 16);
		a = sar32(sar32(p3 * sar32(q * q, 13), 3) + sar32(p2 * a, 1), 18);
		a = sar32((32'd32768 + a) * p1, 15);
		if (a == 32'd0) begin
			dz = 1'b1;
			return 32'd0;
		end
		p = ((32'd1048576 - {12'd0, adc}) - sar32(b, 12)) * 32'd3125;
		// Large dividends are divided before doubling so they do not overflow.
		if (p < 32'h8000_0000)
			p = (p << 1) / a;
		else
			p = (p / a) << 1;
		h = p >> 3;
		a = sar32(p9 * ((h * h) >> 13), 12);
		b = sar32((p >> 2) * p8, 13);
		return p + sar32(a + b + p7, 4);
	endfunction

	// 64-bit pressure path, pascals in Q24.8, truncated to 32 bits.
	function automatic logic [31:0] pressure_q24_8(input logic [31:0] tf,
			input logic [19:0] adc, output logic dz);
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p;
		p1 = {48'd0, cal_press_lo[15:0]};
		p2 = ext64(cal_press_lo[31:16]);
		p3 = ext64(cal_press_lo[47:32]);
		p4 = ext64(cal_press_lo[63:48]);
		p5 = ext64(cal_press_hi[15:0]);
		p6 = ext64(cal_press_hi[31:16]);
		p7 = ext64(cal_press_hi[47:32]);
		p8 = ext64(cal_press_hi[63:48]);
		p9 = ext64(cal_p9);
		dz = 1'b0;
		a = {{32{tf[31]}}, tf} - 64'd128000;
		b = a * a * p6;
		b = b + ((a * p5) << 17);
		b = b + (p4 << 35);
		a = sar64(a * a * p3, 8) + ((a * p2) << 12);
		a = sar64((64'h8000_0000_0000 + a) * p1, 33);
		if (a == 64'd0) begin
			dz = 1'b1;
			return 32'd0;
		end
		p = 64'd1048576 - {44'd0, adc};
		p = div_trunc64(((p << 31) - b) * 64'd3125, a);
		a = sar64(p9 * sar64(p, 13) * sar64(p, 13), 25);
		b = sar64(p8 * p, 19);
		p = sar64(p + a + b, 8) + (p7 << 4);
		return p[31:0];
	endfunction

	// Full compensation of one sample pair under the current calibration.
	function automatic comp_t compensate(input logic [19:0] rt, input logic [19:0] rp);
		logic [31:0] t1, t2, t3, a, b, d, tf;
		comp_t r;
		t1 = {16'd0, cal_temp[15:0]};
		t2 = ext32(cal_temp[31:16]);
		t3 = ext32(cal_temp[47:32]);
		a = sar32((({12'd0, rt} >> 3) - (t1 << 1)) * t2, 11);
		d = ({12'd0, rt} >> 4) - t1;
		b = sar32(sar32(d * d, 12) * t3, 14);
		tf = a + b;
		r.fine = tf;
		r.centi = sar32(tf * 32'd5 + 32'd128, 8);
		if (cal_mode)
			r.press = pressure_q24_8(tf, rp, r.dz);
		else
			r.press = pressure_pa(tf, rp, r.dz);
		return r;
	endfunction

	// Register write; the mirror ignores unused indexes just as the block does.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_TEMP_CAL: cal_temp = data[47:0];
			REG_PRESS_LOW: cal_press_lo = data;
			REG_PRESS_HIGH: cal_press_hi = data;
			REG_PRESS_P9: cal_p9 = data[15:0];
			REG_MODE: cal_mode = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_cal(input logic [47:0] t, input logic [63:0] lo,
			input logic [63:0] hi, input logic [15:0] p9, input logic mode);
		write_reg(REG_TEMP_CAL, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | t);
		write_reg(REG_PRESS_LOW, lo);
		write_reg(REG_PRESS_HIGH, hi);
		write_reg(REG_PRESS_P9, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000 | p9);
		write_reg(REG_MODE, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FFFE | mode);
	endtask

	// Typical factory calibration of a real sensor.
	task automatic load_typical(input logic mode);
		load_cal({16'hFC18, 16'd26435, 16'd27504},
			{16'd2855, 16'd3024, 16'hD643, 16'd36477},
			{16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000, mode);
	endtask

	// Send one request, with a random gap before it unless idling is off.
	task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_temperature <= rt;
		raw_pressure <= rp;
		do @(posedge clk); while (!in_ready);
		reading_q.push_back(compensate(rt, rp));
		requests++;
	endtask

	// Let every outstanding request come back, then let the pipeline drain.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (reading_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_extremes();
		send_sample(20'h00000, 20'h00000);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'h00000, 20'hFFFFF);
		send_sample(20'hFFFFF, 20'h00000);
		send_sample(20'd519888, 20'd415148);
	endtask

	// Field extremes and typical values on both pressure paths.
	task automatic test_directed_paths();
		load_typical(1'b0);
		send_extremes();
		wait_idle();
		load_typical(1'b1);
		send_extremes();
		wait_idle();
	endtask

	// Zero P1 makes the pressure divisor zero on both paths.
	task automatic test_zero_divisor();
		logic m;
		for (int i = 0; i < 2; i++) begin
			m = i[0];
			load_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd2855, 16'd3024, 16'hD643, 16'd0},
				{16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000, m);
			send_sample(20'd519888, 20'd415148);
			send_sample(20'hFFFFF, 20'h00000);
			wait_idle();
		end
	endtask

	// Extreme calibration words force wrap-around; unused indexes must be ignored.
	task automatic test_extreme_cal();
		for (int i = 0; i < 2; i++) begin
			load_cal({3{16'hFFFF}}, {4{16'h8000}}, {4{16'h7FFF}}, 16'h8000, i[0]);
			write_reg(IDX_UNUSED_LO, '1);
			write_reg(IDX_UNUSED_HI, '0);
			send_sample(20'hFFFFF, 20'h00000);
			send_sample(20'h00000, 20'hFFFFF);
			send_sample(20'h5A5A5, 20'hA5A5A);
			wait_idle();
		end
	endtask

	// Random phases: typical, random and extreme calibration on both paths.
	task automatic test_random_phases();
		logic [19:0] rt, rp;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 3)
				0: load_typical(ph[0]);
				1: load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
					{$urandom, $urandom}, 16'($urandom), ph[0]);
				default: load_cal({$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'hFFFF,
					16'hFFFF}, 64'({$urandom, $urandom, 16'hFFFF}),
					{4{$urandom_range(0, 1) ? 16'h7FFF : 16'h8000}}, 16'h7FFF, ph[0]);
			endcase
			no_idle = (ph == 3);
			for (int i = 0; i < 100; i++) begin
				if ($urandom_range(0, 1)) begin
					rt = 20'($urandom);
					rp = 20'($urandom);
				end else begin
					rt = 20'($urandom_range(400000, 600000));
					rp = 20'($urandom_range(200000, 600000));
				end
				// Hold off once until everything in flight has come back.
				if (ph == 2 && i == 50) begin
					in_valid <= 1'b0;
					while (reading_q.size() != 0) @(posedge clk);
				end
				send_sample(rt, rp);
			end
			no_idle = 0;
			wait_idle();
		end
	endtask

	// Result side: random stalls per reading.
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			w = no_idle ? 0 : $urandom_range(0, 15);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Compare each reading with the oldest expectation.
	always @(posedge clk) begin
		comp_t e;
		if (out_valid && out_ready) begin
			if (reading_q.size() == 0) begin
				$error("reading with no request outstanding");
				errors++;
			end else begin
				e = reading_q.pop_front();
				readings++;
				if (e.dz) dz_count++;
				if (temperature_centi !== e.centi) begin
					$error("temperature_centi expected %0d got %0d",
						$signed(e.centi), temperature_centi);
					errors++;
				end
				if (fine_temperature !== e.fine) begin
					$error("fine_temperature expected %0d got %0d",
						$signed(e.fine), fine_temperature);
					errors++;
				end
				if (pressure !== e.press) begin
					$error("pressure expected %0d got %0d", e.press, pressure);
					errors++;
				end
				if (divide_by_zero !== e.dz) begin
					$error("divide_by_zero expected %0b got %0b", e.dz, divide_by_zero);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted request or reading.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[pressure_temperature_compensation] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_paths();
		test_zero_divisor();
		test_extreme_cal();
		test_random_phases();
		wait_idle();
		$display("Covered %0d requests and %0d readings on both pressure paths,", requests,
			readings);
		$display("with %0d zero-divisor readings and %0d mismatches.", dz_count, errors);
		if (errors == 0 && reading_q.size() == 0)
			$display("[pressure_temperature_compensation] OK");
		else
			$display("[pressure_temperature_compensation] ERROR");
		$finish;
	end

endmodule
